// File: design/sff_pkg.sv
// shared types and constants for the system-use field framer
package sff_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FIELD = 2'd0,
        KIND_CONT  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } sff_kind_t;

    // one result item
    typedef struct packed {
        sff_kind_t   kind;
        logic [7:0]  sig_first;
        logic [7:0]  sig_second;
        logic [7:0]  field_length;
        logic [11:0] field_start;
        logic [7:0]  ext_index;
        logic [31:0] cont_block;
        logic [14:0] cont_offset;
        logic [31:0] cont_size;
        logic        last_of_run;
    } sff_result_t;

    // signatures and field rules
    localparam logic [15:0] SIG_CE       = 16'h4345;
    localparam logic [15:0] SIG_ES       = 16'h4553;
    localparam logic [15:0] SIG_ST       = 16'h5354;
    localparam logic [7:0]  SUSP_VERSION = 8'd1;
    localparam logic [7:0]  CE_MIN_LEN   = 8'd28;
    localparam logic [7:0]  ES_MIN_LEN   = 8'd5;
    localparam logic [7:0]  HDR_LEN      = 8'd4;

    // block size register
    localparam logic [3:0]  BSL_MIN      = 4'd9;
    localparam logic [3:0]  BSL_RESET    = 4'd11;

    // defaults for top-level parameters
    localparam int AREA_BYTES_DEF = 4096;
    localparam int OQ_DEPTH_DEF   = 4;

endpackage

// File: design/susp_field_framer.sv
// top level of the system-use field framer
// One byte of a system-use area is taken per cycle while the result queue has
// room for two results. A byte is held in an input register, where the framing
// logic updates the field state and forms its results, which go into a small
// result queue (QUEUE_DEPTH entries); a result is on the output from the clock
// edge after the byte transfer at the earliest. A byte yields no, one or two
// results: two when it both completes a reported field and is the last byte of
// the area. The queue gives one result per cycle on the output side, so a run
// of bytes that each give two results is limited by the output; every other
// stream runs at one byte per cycle while the output keeps taking results.
// The user must write block size through cfg_wr_en / cfg_wr_data while no
// byte is in flight; the block itself does not enforce this.
module susp_field_framer
    import sff_pkg::*;
#(
    parameter int AREA_BYTES  = AREA_BYTES_DEF,
    parameter int QUEUE_DEPTH = OQ_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_value,
    input  logic        first_of_record,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  sig_first,
    output logic [7:0]  sig_second,
    output logic [7:0]  field_length,
    output logic [11:0] field_start,
    output logic [7:0]  ext_index,
    output logic [31:0] cont_block,
    output logic [14:0] cont_offset,
    output logic [31:0] cont_size,
    output logic        last_of_run
);

    localparam int POS_W = $clog2(AREA_BYTES);

    // configuration
    logic [3:0]       bsl_reg;

    // input register
    logic             hold_valid_reg;
    logic [7:0]       hold_byte_reg;
    logic             hold_first_reg;
    logic             hold_last_reg;

    // framing state
    logic [POS_W-1:0] pos_reg,   pos_c,   pos_next;
    logic [POS_W-1:0] fsp_reg,   fsp_c,   fsp_next;
    logic [7:0]       bif_reg,   bif_c,   bif_next;
    logic [7:0]       len_reg,   len_c,   len_next;
    logic [15:0]      sig_reg,   sig_c,   sig_next;
    logic [7:0]       ver_reg,   ver_c,   ver_next;
    logic [7:0]       ext_reg,   ext_c,   ext_next;
    logic             stop_reg,  stop_c,  stop_next;
    logic [31:0]      blk_reg,   blk_c,   blk_next;
    logic [31:0]      off_reg,   off_c,   off_next;
    logic [31:0]      size_reg,  size_c,  size_next;

    // per-byte work
    logic             advance;
    logic             room_for_two;
    logic             is_ce;
    logic             is_es;
    logic             field_push;
    logic             area_err;
    logic [3:0]       lg;
    logic [31:0]      extra_blocks;
    logic [31:0]      off_mask;
    logic [31:0]      off_rest;
    logic [32:0]      blk_sum;
    logic [POS_W+11:0] fsp_wide;
    sff_result_t      field_res;
    sff_result_t      close_res;
    sff_result_t      push_first;
    sff_result_t      push_second;
    logic [1:0]       push_cnt;
    sff_result_t      out_data;

    // input handshake
    assign advance    = hold_valid_reg && room_for_two;
    assign byte_ready = !hold_valid_reg || advance;

    // block size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsl_reg <= BSL_RESET;
        end
        else if (cfg_wr_en)
        begin
            bsl_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            hold_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            hold_byte_reg  <= byte_value;
            hold_first_reg <= first_of_record;
            hold_last_reg  <= last_byte;
        end
    end

    // state seen by the byte, cleared on the first byte of a record
    always_comb
    begin
        pos_c  = pos_reg;
        fsp_c  = fsp_reg;
        bif_c  = bif_reg;
        len_c  = len_reg;
        sig_c  = sig_reg;
        ver_c  = ver_reg;
        ext_c  = ext_reg;
        stop_c = stop_reg;
        blk_c  = blk_reg;
        off_c  = off_reg;
        size_c = size_reg;
        if (hold_first_reg)
        begin
            pos_c  = '0;
            fsp_c  = '0;
            bif_c  = '0;
            len_c  = '0;
            sig_c  = '0;
            ver_c  = '0;
            ext_c  = '0;
            stop_c = 1'b0;
            blk_c  = '0;
            off_c  = '0;
            size_c = '0;
        end
    end

    // field framing and area close
    always_comb
    begin
        pos_next   = pos_c;
        fsp_next   = fsp_c;
        bif_next   = bif_c;
        len_next   = len_c;
        sig_next   = sig_c;
        ver_next   = ver_c;
        ext_next   = ext_c;
        stop_next  = stop_c;
        blk_next   = blk_c;
        off_next   = off_c;
        size_next  = size_c;
        is_ce      = 1'b0;
        is_es      = 1'b0;
        field_push = 1'b0;

        if (!stop_c)
        begin
            // header capture
            if (bif_c == 8'd0)
            begin
                fsp_next = pos_c;
                sig_next = {hold_byte_reg, sig_c[7:0]};
            end
            else if (bif_c == 8'd1)
            begin
                sig_next = {sig_c[15:8], hold_byte_reg};
            end
            else if (bif_c == 8'd2)
            begin
                len_next = hold_byte_reg;
            end
            else if (bif_c == 8'd3)
            begin
                ver_next = hold_byte_reg;
            end
            bif_next = bif_c + 8'd1;

            is_ce = (sig_next == SIG_CE) && (ver_next == SUSP_VERSION) &&
                    (len_next >= CE_MIN_LEN);
            is_es = (sig_next == SIG_ES) && (ver_next == SUSP_VERSION) &&
                    (len_next >= ES_MIN_LEN);

            // body bytes and field end
            if ((bif_c == 8'd3) && (len_next < HDR_LEN))
            begin
                stop_next = 1'b1;
            end
            else if (bif_c >= 8'd3)
            begin
                if (is_ce)
                begin
                    if ((bif_c >= 8'd4) && (bif_c <= 8'd7))
                    begin
                        blk_next[{bif_c[1:0], 3'b000} +: 8] = hold_byte_reg;
                    end
                    else if ((bif_c >= 8'd12) && (bif_c <= 8'd15))
                    begin
                        off_next[{bif_c[1:0], 3'b000} +: 8] = hold_byte_reg;
                    end
                    else if ((bif_c >= 8'd20) && (bif_c <= 8'd23))
                    begin
                        size_next[{bif_c[1:0], 3'b000} +: 8] = hold_byte_reg;
                    end
                end
                else if (is_es && (bif_c == 8'd4))
                begin
                    ext_next = hold_byte_reg;
                end
                if (bif_next == len_next)
                begin
                    bif_next = '0;
                    if (is_ce || is_es)
                    begin
                        field_push = 1'b0;
                    end
                    else if ((sig_next == SIG_ST) && (ver_next == SUSP_VERSION))
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        field_push = 1'b1;
                    end
                end
            end
        end

        // area position wraps at the area size
        if (pos_c == POS_W'(AREA_BYTES - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_c + 1'b1;
        end

        // reported field
        fsp_wide               = {12'b0, fsp_next};
        field_res              = '0;
        field_res.kind         = KIND_FIELD;
        field_res.sig_first    = sig_next[15:8];
        field_res.sig_second   = sig_next[7:0];
        field_res.field_length = len_next;
        field_res.field_start  = fsp_wide[11:0];
        field_res.ext_index    = ext_next;
        field_res.last_of_run  = !hold_last_reg;

        // continuation split: whole blocks and remainder
        lg           = (bsl_reg < BSL_MIN) ? BSL_MIN : bsl_reg;
        extra_blocks = off_next >> lg;
        off_mask     = ~(32'hFFFF_FFFF << lg);
        off_rest     = off_next & off_mask;
        blk_sum      = {1'b0, blk_next} + {1'b0, extra_blocks};

        // closing result
        area_err  = (stop_next && (len_next < HDR_LEN)) ||
                    (!stop_next && (bif_next >= HDR_LEN));
        close_res = '0;
        close_res.last_of_run = 1'b1;
        if (!area_err && (size_next != 32'd0))
        begin
            if (blk_sum[32])
            begin
                area_err = 1'b1;
            end
            else
            begin
                close_res.cont_block  = blk_sum[31:0];
                close_res.cont_offset = off_rest[14:0];
                close_res.cont_size   = size_next;
            end
        end
        if (area_err)
        begin
            close_res.kind = KIND_ERROR;
        end
        else if (close_res.cont_size != 32'd0)
        begin
            close_res.kind = KIND_CONT;
        end
        else
        begin
            close_res.kind = KIND_END;
        end

        // area end clears framing and continuation
        if (hold_last_reg)
        begin
            if (area_err)
            begin
                ext_next = '0;
            end
            pos_next  = '0;
            fsp_next  = '0;
            bif_next  = '0;
            len_next  = '0;
            sig_next  = '0;
            ver_next  = '0;
            stop_next = 1'b0;
            blk_next  = '0;
            off_next  = '0;
            size_next = '0;
        end
    end

    // results into the queue
    always_comb
    begin
        push_first  = field_push ? field_res : close_res;
        push_second = close_res;
        push_cnt    = 2'd0;
        if (advance)
        begin
            push_cnt = 2'(field_push) + 2'(hold_last_reg);
        end
    end

    // framing state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fsp_reg  <= '0;
            bif_reg  <= '0;
            len_reg  <= '0;
            sig_reg  <= '0;
            ver_reg  <= '0;
            ext_reg  <= '0;
            stop_reg <= 1'b0;
            blk_reg  <= '0;
            off_reg  <= '0;
            size_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            fsp_reg  <= fsp_next;
            bif_reg  <= bif_next;
            len_reg  <= len_next;
            sig_reg  <= sig_next;
            ver_reg  <= ver_next;
            ext_reg  <= ext_next;
            stop_reg <= stop_next;
            blk_reg  <= blk_next;
            off_reg  <= off_next;
            size_reg <= size_next;
        end
    end

    sff_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push_first   (push_first),
        .push_second  (push_second),
        .room_for_two (room_for_two),
        .out_valid    (result_valid),
        .out_ready    (result_ready),
        .out_data     (out_data)
    );

    // result fields
    assign result_kind  = out_data.kind;
    assign sig_first    = out_data.sig_first;
    assign sig_second   = out_data.sig_second;
    assign field_length = out_data.field_length;
    assign field_start  = out_data.field_start;
    assign ext_index    = out_data.ext_index;
    assign cont_block   = out_data.cont_block;
    assign cont_offset  = out_data.cont_offset;
    assign cont_size    = out_data.cont_size;
    assign last_of_run  = out_data.last_of_run;

`ifndef ASSERT_OFF
    // the last byte of an area leaves the framing state clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hold_last_reg) |=>
            (pos_reg == '0) && (bif_reg == '0) && !stop_reg && (size_reg == '0))
        else $error("framing state not cleared at area end");

    // closing results always end the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind != KIND_FIELD)) |-> last_of_run)
        else $error("closing result without last_of_run");

    // a continuation result carries a size
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_CONT)) |-> (cont_size != 32'd0))
        else $error("continuation result with zero size");
`endif

endmodule

// File: design/sff_out_queue.sv
// result queue taking up to two results per cycle and giving one per transfer
module sff_out_queue
    import sff_pkg::*;
#(
    parameter int DEPTH = OQ_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_cnt,
    input  sff_result_t push_first,
    input  sff_result_t push_second,
    output logic        room_for_two,
    output logic        out_valid,
    input  logic        out_ready,
    output sff_result_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sff_result_t       mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // handshake and room
    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_cnt == 2'd1)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        else if (push_cnt == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        if (pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push_second;
        end
    end

`ifndef ASSERT_OFF
    // a push never goes beyond the free entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(count_reg) + int'(push_cnt)) <= DEPTH)
        else $error("result queue overflow");
`endif

endmodule

// File: dv/sff_checker.sv
// checker for the system-use field framer: predicts results per byte transfer and compares
`timescale 1ns / 100ps
module sff_checker
    import sff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  logic [7:0]  byte_value,
    input  logic        first_of_record,
    input  logic        last_byte,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  result_kind,
    input  logic [7:0]  sig_first,
    input  logic [7:0]  sig_second,
    input  logic [7:0]  field_length,
    input  logic [11:0] field_start,
    input  logic [7:0]  ext_index,
    input  logic [31:0] cont_block,
    input  logic [14:0] cont_offset,
    input  logic [31:0] cont_size,
    input  logic        last_of_run,
    output int          fail_count,
    output int          outstanding,
    output int          bytes_seen,
    output int          fields_seen,
    output int          conts_seen,
    output int          ends_seen,
    output int          errors_seen
);

    // predicted framer state
    logic [3:0]  blk_log2;
    int          area_pos;
    int          fld_start;
    logic [7:0]  fld_count;
    logic [7:0]  fld_len;
    logic [7:0]  fld_ver;
    logic [15:0] fld_sig;
    logic [7:0]  ext_sel;
    logic        halted;
    logic [31:0] ce_block;
    logic [31:0] ptr_offset;
    logic [31:0] ce_size;

    // results owed by the block, oldest first
    sff_result_t framed_results [$];

    int errs    = 0;
    int n_bytes = 0;
    int n_field = 0;
    int n_cont  = 0;
    int n_end   = 0;
    int n_err   = 0;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errs < 40)
            $display("sff_checker: %s mismatch, got %0h expected %0h", what, got, want);
        errs++;
    endtask

    // drop framing state and pending continuation, keep the extension selector
    task automatic clear_framing();
        area_pos   = 0;
        fld_start  = 0;
        fld_count  = '0;
        fld_len    = '0;
        fld_sig    = '0;
        fld_ver    = '0;
        halted     = 1'b0;
        ce_block   = '0;
        ptr_offset = '0;
        ce_size    = '0;
    endtask

    // frame one byte and queue the results it causes
    task automatic frame_byte(input logic [7:0] b, input logic first, input logic last);
        logic [7:0]  idx;
        logic        is_ce;
        logic        is_es;
        logic        err;
        int          lg;
        int          n;
        logic [31:0] extra;
        logic [31:0] cb;
        logic [31:0] co;
        logic [31:0] cs;
        sff_result_t r;
        sff_result_t made [2];

        n = 0;
        if (first) begin
            clear_framing();
            ext_sel = '0;
        end

        if (!halted) begin
            idx = fld_count;
            if (idx == 0) begin
                fld_start     = area_pos;
                fld_sig[15:8] = b;
            end
            else if (idx == 1)
                fld_sig[7:0] = b;
            else if (idx == 2)
                fld_len = b;
            else if (idx == 3)
                fld_ver = b;
            fld_count = idx + 8'd1;

            is_ce = (fld_sig == SIG_CE) && (fld_ver == SUSP_VERSION) && (fld_len >= CE_MIN_LEN);
            is_es = (fld_sig == SIG_ES) && (fld_ver == SUSP_VERSION) && (fld_len >= ES_MIN_LEN);

            if (idx == 3 && fld_len < HDR_LEN)
                halted = 1'b1;
            else if (idx >= 3) begin
                // continuation pointer lanes, little endian
                if (is_ce) begin
                    if (idx >= 4 && idx <= 7)
                        ce_block[8*(idx-4) +: 8] = b;
                    else if (idx >= 12 && idx <= 15)
                        ptr_offset[8*(idx-12) +: 8] = b;
                    else if (idx >= 20 && idx <= 23)
                        ce_size[8*(idx-20) +: 8] = b;
                end
                else if (is_es && idx == 4)
                    ext_sel = b;

                // field complete
                if (fld_count == fld_len) begin
                    fld_count = '0;
                    if (!(is_ce || is_es)) begin
                        if (fld_sig == SIG_ST && fld_ver == SUSP_VERSION)
                            halted = 1'b1;
                        else begin
                            r              = '0;
                            r.kind         = KIND_FIELD;
                            r.sig_first    = fld_sig[15:8];
                            r.sig_second   = fld_sig[7:0];
                            r.field_length = fld_len;
                            r.field_start  = fld_start[11:0];
                            r.ext_index    = ext_sel;
                            made[n]        = r;
                            n++;
                        end
                    end
                end
            end
        end

        area_pos = (area_pos + 1) % AREA_BYTES_DEF;

        // closing result at the area end
        if (last) begin
            err = 1'b0;
            cb  = '0;
            co  = '0;
            cs  = '0;
            if (halted && fld_len < HDR_LEN)
                err = 1'b1;
            else if (!halted && fld_count >= HDR_LEN)
                err = 1'b1;
            if (!err && ce_size != 0) begin
                lg    = (blk_log2 < BSL_MIN) ? int'(BSL_MIN) : int'(blk_log2);
                extra = ptr_offset >> lg;
                co    = ptr_offset & ((32'd1 << lg) - 32'd1);
                if (32'hFFFF_FFFF - ce_block < extra) begin
                    err = 1'b1;
                    co  = '0;
                end
                else begin
                    cb = ce_block + extra;
                    cs = ce_size;
                end
            end
            r             = '0;
            r.cont_block  = cb;
            r.cont_offset = co[14:0];
            r.cont_size   = cs;
            if (err) begin
                r.kind  = KIND_ERROR;
                ext_sel = '0;
            end
            else
                r.kind = (cs != 0) ? KIND_CONT : KIND_END;
            made[n] = r;
            n++;
            clear_framing();
        end

        if (n > 0)
            made[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            framed_results.push_back(made[i]);
    endtask

    // compare one result transfer with the oldest owed result
    task automatic check_result();
        sff_result_t want;
        if (framed_results.size() == 0)
            note_mismatch("result with nothing owed, kind", 32'(result_kind), '0);
        else begin
            want = framed_results.pop_front();
            if (result_kind != want.kind)
                note_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
            if (sig_first != want.sig_first)
                note_mismatch("sig_first", 32'(sig_first), 32'(want.sig_first));
            if (sig_second != want.sig_second)
                note_mismatch("sig_second", 32'(sig_second), 32'(want.sig_second));
            if (field_length != want.field_length)
                note_mismatch("field_length", 32'(field_length), 32'(want.field_length));
            if (field_start != want.field_start)
                note_mismatch("field_start", 32'(field_start), 32'(want.field_start));
            if (ext_index != want.ext_index)
                note_mismatch("ext_index", 32'(ext_index), 32'(want.ext_index));
            if (cont_block != want.cont_block)
                note_mismatch("cont_block", cont_block, want.cont_block);
            if (cont_offset != want.cont_offset)
                note_mismatch("cont_offset", 32'(cont_offset), 32'(want.cont_offset));
            if (cont_size != want.cont_size)
                note_mismatch("cont_size", cont_size, want.cont_size);
            if (last_of_run != want.last_of_run)
                note_mismatch("last_of_run", 32'(last_of_run), 32'(want.last_of_run));
            case (want.kind)
                KIND_FIELD: n_field++;
                KIND_CONT:  n_cont++;
                KIND_END:   n_end++;
                default:    n_err++;
            endcase
        end
    endtask

    // watch both channels and the block size register
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            blk_log2 = BSL_RESET;
            ext_sel  = '0;
            clear_framing();
            framed_results.delete();
            fail_count  <= errs;
            outstanding <= 0;
        end
        else begin
            if (cfg_wr_en)
                blk_log2 = cfg_wr_data;
            if (byte_valid && byte_ready) begin
                frame_byte(byte_value, first_of_record, last_byte);
                n_bytes++;
            end
            if (result_valid && result_ready)
                check_result();
            fail_count  <= errs;
            outstanding <= framed_results.size();
            bytes_seen  <= n_bytes;
            fields_seen <= n_field;
            conts_seen  <= n_cont;
            ends_seen   <= n_end;
            errors_seen <= n_err;
        end
    end

endmodule

// File: dv/tb.sv
// testbench top for the system-use field framer: clock, reset, area stimulus and verdict
`timescale 1ns / 100ps
module tb;
    import sff_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 430;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       last;
    } area_byte_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [3:0]  cfg_wr_data     = '0;
    logic        byte_valid      = 1'b0;
    logic        byte_ready;
    logic [7:0]  byte_value      = '0;
    logic        first_of_record = 1'b0;
    logic        last_byte       = 1'b0;
    logic        result_valid;
    logic        result_ready    = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  sig_first;
    logic [7:0]  sig_second;
    logic [7:0]  field_length;
    logic [11:0] field_start;
    logic [7:0]  ext_index;
    logic [31:0] cont_block;
    logic [14:0] cont_offset;
    logic [31:0] cont_size;
    logic        last_of_run;

    int fail_count;
    int outstanding;
    int bytes_seen;
    int fields_seen;
    int conts_seen;
    int ends_seen;
    int errors_seen;

    int src_idle = 0;
    int dst_idle = 0;
    int quiet    = 0;
    int sent     = 0;

    area_byte_t area_q [$];

    susp_field_framer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .byte_value      (byte_value),
        .first_of_record (first_of_record),
        .last_byte       (last_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .sig_first       (sig_first),
        .sig_second      (sig_second),
        .field_length    (field_length),
        .field_start     (field_start),
        .ext_index       (ext_index),
        .cont_block      (cont_block),
        .cont_offset     (cont_offset),
        .cont_size       (cont_size),
        .last_of_run     (last_of_run)
    );

    sff_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .byte_value      (byte_value),
        .first_of_record (first_of_record),
        .last_byte       (last_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .sig_first       (sig_first),
        .sig_second      (sig_second),
        .field_length    (field_length),
        .field_start     (field_start),
        .ext_index       (ext_index),
        .cont_block      (cont_block),
        .cont_offset     (cont_offset),
        .cont_size       (cont_size),
        .last_of_run     (last_of_run),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .bytes_seen      (bytes_seen),
        .fields_seen     (fields_seen),
        .conts_seen      (conts_seen),
        .ends_seen       (ends_seen),
        .errors_seen     (errors_seen)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= dst_idle);
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (result_valid && result_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: watchdog expired after %0d quiet cycles", quiet);
            $display("tb: failure");
            $finish;
        end
    end

    // one byte transfer, with random sender gaps in front
    task automatic send_item(input area_byte_t it);
        while ($urandom_range(99) < src_idle) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid      <= 1'b1;
        byte_value      <= it.b;
        first_of_record <= it.first;
        last_byte       <= it.last;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        area_byte_t it;
        it.b     = b;
        it.first = 1'b0;
        it.last  = 1'b0;
        area_q.push_back(it);
    endtask

    task automatic add_hdr(input logic [15:0] sig, input logic [7:0] len, input logic [7:0] ver);
        push_byte(sig[15:8]);
        push_byte(sig[7:0]);
        push_byte(len);
        push_byte(ver);
    endtask

    task automatic add_body(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(255)));
    endtask

    // continuation pointer field with block, offset and size lanes
    task automatic add_ce(input logic [31:0] blk, input logic [31:0] off,
                          input logic [31:0] size, input int len);
        add_hdr(SIG_CE, len[7:0], SUSP_VERSION);
        for (int i = 4; i < len; i++) begin
            if (i <= 7)
                push_byte(blk[8*(i-4) +: 8]);
            else if (i >= 12 && i <= 15)
                push_byte(off[8*(i-12) +: 8]);
            else if (i >= 20 && i <= 23)
                push_byte(size[8*(i-20) +: 8]);
            else
                push_byte(8'($urandom_range(255)));
        end
    endtask

    // send the built area, marking its final byte and, for a new record, its first
    task automatic send_area(input logic new_record);
        area_byte_t it;
        for (int i = 0; i < area_q.size(); i++) begin
            it       = area_q[i];
            it.first = new_record && (i == 0);
            it.last  = (i == area_q.size() - 1);
            send_item(it);
        end
        area_q.delete();
    endtask

    // wait until nothing is owed, then let in-flight bytes settle
    task automatic drain(input int hold);
        byte_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    task automatic set_block_size(input logic [3:0] v);
        drain(8);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly well-formed area of random fields, with a broken tail now and then
    task automatic random_area();
        int          nf;
        int          pick;
        int          len;
        logic [15:0] sig;
        logic [31:0] blk;
        logic [31:0] off;
        logic [31:0] sz;

        nf = $urandom_range(5);
        while (nf > 0) begin
            pick = $urandom_range(99);
            nf--;
            if (pick < 45) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(255, 4) : $urandom_range(24, 4);
                add_hdr(16'($urandom), len[7:0], 8'($urandom_range(255)));
                add_body(len - 4);
            end
            else if (pick < 60) begin
                len = $urandom_range(8, 5);
                add_hdr(SIG_ES, len[7:0], SUSP_VERSION);
                push_byte(8'($urandom_range(255)));
                add_body(len - 5);
            end
            else if (pick < 75) begin
                case ($urandom_range(3))
                    0: blk = $urandom;
                    1: blk = 32'hFFFF_FFFF - $urandom_range(3);
                    2: blk = '0;
                    default: blk = $urandom_range(1000);
                endcase
                case ($urandom_range(3))
                    0: off = $urandom;
                    1: off = $urandom_range(65535);
                    2: off = '0;
                    default: off = 32'hFFFF_FFFF;
                endcase
                case ($urandom_range(3))
                    0: sz = '0;
                    1: sz = $urandom;
                    2: sz = $urandom_range(4096, 1);
                    default: sz = 32'hFFFF_FFFF;
                endcase
                add_ce(blk, off, sz, $urandom_range(34, 28));
            end
            else if (pick < 85) begin
                // near misses of the special signatures: reported as plain fields
                case ($urandom_range(2))
                    0: sig = SIG_CE;
                    1: sig = SIG_ES;
                    default: sig = SIG_ST;
                endcase
                if ($urandom_range(1) == 0) begin
                    len = $urandom_range(12, 4);
                    add_hdr(sig, len[7:0], 8'(SUSP_VERSION + 8'd1 + $urandom_range(3)));
                end
                else begin
                    len = (sig == SIG_CE) ? 27 : 4;
                    add_hdr(sig, len[7:0], (sig == SIG_ST) ? 8'd0 : SUSP_VERSION);
                end
                add_body(len - 4);
            end
            else begin
                // stop field, then ignored trailing bytes
                add_hdr(SIG_ST, HDR_LEN, SUSP_VERSION);
                add_body($urandom_range(6));
                nf = 0;
            end
        end

        case ($urandom_range(9))
            0: begin
                // length under the header size
                add_hdr(16'($urandom), 8'($urandom_range(3)), 8'($urandom_range(255)));
                add_body($urandom_range(4));
            end
            1: begin
                // body cut by the area end
                len = $urandom_range(40, 10);
                add_hdr(16'($urandom), len[7:0], 8'($urandom_range(255)));
                add_body($urandom_range(len - 5));
            end
            2: add_body($urandom_range(3, 1));
            default: ;
        endcase
        if (area_q.size() == 0)
            push_byte(8'($urandom_range(255)));
    endtask

    task automatic run_phase(input int s_idle, input int d_idle, input logic [3:0] bsl);
        int         areas;
        int         start;
        int         n;
        area_byte_t it;

        set_block_size(bsl);
        src_idle = s_idle;
        dst_idle = d_idle;
        areas    = 0;
        start    = sent;
        while (sent - start < ITEMS_PER_PHASE) begin
            if (areas % 7 == 6)
                set_block_size(4'($urandom_range(15)));
            if ($urandom_range(99) < 12) begin
                // loose bytes with random record and area marks
                n = $urandom_range(6, 1);
                repeat (n) begin
                    it.b     = 8'($urandom_range(255));
                    it.first = ($urandom_range(9) == 0);
                    it.last  = ($urandom_range(4) == 0);
                    send_item(it);
                end
            end
            else begin
                random_area();
                send_area($urandom_range(9) < 7);
            end
            areas++;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed areas at the reset block size
        // field completed on the area's final byte
        add_hdr(16'h5058, HDR_LEN, 8'hFF);
        send_area(1'b1);
        // extension selector set and reported
        add_hdr(SIG_ES, ES_MIN_LEN, SUSP_VERSION);
        push_byte(8'hFF);
        add_hdr(16'h0000, HDR_LEN, 8'h00);
        send_area(1'b1);
        // selector kept into the next area of the same record
        add_hdr(16'hFFFF, 8'd6, SUSP_VERSION);
        add_body(2);
        send_area(1'b0);
        // block number overflow
        add_ce(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, int'(CE_MIN_LEN));
        send_area(1'b0);
        // continuation, stop field, ignored trailing bytes
        add_ce(32'd5, 32'h0000_1234, 32'hFFFF_FFFF, int'(CE_MIN_LEN));
        add_hdr(SIG_ST, HDR_LEN, SUSP_VERSION);
        add_body(2);
        send_area(1'b1);
        // length byte under four
        add_hdr(16'h4142, 8'd3, SUSP_VERSION);
        add_body(3);
        send_area(1'b1);
        // field overrunning the area
        add_hdr(16'h4142, 8'd10, SUSP_VERSION);
        add_body(2);
        send_area(1'b1);
        // short leftover after a field
        add_hdr(16'h4142, HDR_LEN, 8'h00);
        add_body(2);
        send_area(1'b1);
        // one-byte area
        push_byte(8'h00);
        send_area(1'b1);
        // pointer with zero size gives a plain end
        add_ce(32'd7, 32'd100, 32'd0, 30);
        send_area(1'b1);

        // random areas under three idle mixes
        run_phase(28, 56, 4'd0);
        run_phase(56, 28, 4'd15);
        run_phase(0, 0, BSL_MIN);

        drain(20);
        $display("summary: %0d bytes framed; %0d fields, %0d continuations, %0d ends, %0d errors",
                 bytes_seen, fields_seen, conts_seen, ends_seen, errors_seen);
        $display("summary: three stall mixes, block sizes below range up to 15, broken tails");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
